// ===== sv/quadratic_root_solver_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Shared wrappers so that every concurrent check uses the same clock; QRS_ASSERT adds the reset.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define QRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define QRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/qrs_pkg.sv =====
// ---------------------------------------------------------------------------
// qrs_pkg
// Widths, result kind codes and the single-step arithmetic of the solver.
// ---------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int CoefW  = 16;
  localparam int SqrtN  = 25;  // result bits of the square root
  localparam int RadW   = 2 * SqrtN;
  localparam int SremW  = 27;
  localparam int NumW   = 34;  // numerator magnitude and quotient width
  localparam int DenW   = 17;
  localparam int DremW  = 18;
  localparam int InW    = 3 * CoefW;
  localparam int OutW   = 96;
  localparam int UserW  = 4;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_LINEAR  = 3'd1;
  localparam logic [2:0] KIND_TWO     = 3'd2;
  localparam logic [2:0] KIND_DOUBLE  = 3'd3;
  localparam logic [2:0] KIND_COMPLEX = 3'd4;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [SremW-1:0] rem;
    logic [SqrtN-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DremW-1:0] rem;
    logic [NumW-1:0]  nq;
  } div_t;

  // One restoring square-root step: brings in two radicand bits, yields one root bit.
  function automatic sqrt_t sqrt_step(input sqrt_t x);
    sqrt_t       y;
    logic [28:0] cur;
    logic [28:0] trial;
    cur   = {x.rem, x.rad[RadW-1 -: 2]};
    trial = {2'b00, x.root, 2'b01};
    y.rad = {x.rad[RadW-3:0], 2'b00};
    if (cur >= trial) begin
      y.rem  = SremW'(cur - trial);
      y.root = {x.root[SqrtN-2:0], 1'b1};
    end else begin
      y.rem  = SremW'(cur);
      y.root = {x.root[SqrtN-2:0], 1'b0};
    end
    return y;
  endfunction

  // One restoring division step: the numerator shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  function automatic div_t div_step(input div_t x, input logic [DenW-1:0] den);
    div_t        y;
    logic [DremW:0] cur;
    cur = {x.rem, x.nq[NumW-1]};
    if (cur >= {2'b00, den}) begin
      y.rem = DremW'(cur - {2'b00, den});
      y.nq  = {x.nq[NumW-2:0], 1'b1};
    end else begin
      y.rem = DremW'(cur);
      y.nq  = {x.nq[NumW-2:0], 1'b0};
    end
    return y;
  endfunction

  // Applies the sign to a quotient magnitude and saturates to Q16.16.
  // Returns {saturated, value}.
  function automatic logic [32:0] sign_sat(input logic [NumW-1:0] q, input logic neg);
    logic [32:0] r;
    if (!neg) begin
      if (q > NumW'(34'h0_7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
      else                            r = {1'b0, q[31:0]};
    end else begin
      if (q > NumW'(34'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
      else                            r = {1'b0, 32'(-q[31:0])};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/quadratic_root_solver.sv =====
// ---------------------------------------------------------------------------
// quadratic_root_solver
// Fully pipelined fixed-point solver for a*x^2 + b*x + c = 0.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    coef_a, coef_b, coef_c
//  m_axis    out        m_axis_tvalid/m_axis_tready    roots, disc_sqrt, kind, flag
//
// One beat enters per clock while the output is not stalled. The pipeline is two
// multiply/discriminant stages, 25 square-root stages, one operand stage,
// 34 divider stages and the output register.
// rst is synchronous and active high; it clears every valid bit and the skid
// full flag, data registers are not reset.
// When the output is stalled the whole pipeline holds; a one-beat skid
// register on the input still takes the beat offered in that cycle.
//
// The discriminant D = b*b - 4ac is formed exactly from two 16x16 products.
// floor(sqrt(|D| * 2^16)) comes from a restoring square root, one bit per
// stage. Two restoring dividers, one quotient bit per stage, share the
// denominator and produce the two roots from magnitudes; the sign is applied
// and the result saturated to Q16.16 at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
  input  wire logic [qrs_pkg::InW-1:0]     s_axis_tdata,
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [31:0] root_first, [63:32] root_second, [94:64] disc_sqrt, [95] zero
  output      logic [qrs_pkg::OutW-1:0]    m_axis_tdata,
  // [2:0] root_kind, [3] overflow
  output      logic [qrs_pkg::UserW-1:0]   m_axis_tuser
);
  import qrs_pkg::*;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [CoefW-1:0]  a;
    logic signed [CoefW-1:0]  b;
    logic signed [CoefW-1:0]  c;
    sqrt_t                    sq;
  } root_stage_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SqrtN-1:0] s;
    logic [DenW-1:0]  den;
    logic             neg1;
    logic             neg2;
    div_t             d1;
    div_t             d2;
  } div_stage_t;

  // The whole pipeline advances together whenever the output can move.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;

  // Input skid register: catches the beat accepted while the pipeline holds.
  logic            skid_full;
  logic [InW-1:0]  skid_data;
  logic            in_valid;
  logic [InW-1:0]  in_data;

  assign s_axis_tready = !skid_full;
  assign in_valid      = skid_full || s_axis_tvalid;
  assign in_data       = skid_full ? skid_data : s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (s_axis_tvalid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_axis_tvalid && !skid_full) begin
      skid_data <= s_axis_tdata;
    end
  end

  // Stage 1: the two products.
  logic                    s1_valid;
  logic signed [CoefW-1:0] s1_a, s1_b, s1_c;
  logic signed [31:0]      s1_bb, s1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a  <= in_data[CoefW-1:0];
      s1_b  <= in_data[2*CoefW-1:CoefW];
      s1_c  <= in_data[3*CoefW-1:2*CoefW];
      s1_bb <= $signed(in_data[2*CoefW-1:CoefW]) * $signed(in_data[2*CoefW-1:CoefW]);
      s1_ac <= $signed(in_data[CoefW-1:0]) * $signed(in_data[3*CoefW-1:2*CoefW]);
    end
  end

  // Stage 2: discriminant, its magnitude and the kind of solution.
  logic signed [33:0] disc;
  logic [33:0]        disc_mag;
  root_stage_t        s2_next;

  always_comb begin
    disc     = 34'(s1_bb) - (34'(s1_ac) <<< 2);
    disc_mag = disc[33] ? 34'(-disc) : disc;
    s2_next.a = s1_a;
    s2_next.b = s1_b;
    s2_next.c = s1_c;
    s2_next.sq.rem  = '0;
    s2_next.sq.root = '0;
    s2_next.sq.rad  = {1'b0, disc_mag[32:0], 16'h0000};
    if (s1_a == '0 && s1_b == '0) begin
      s2_next.kind   = KIND_NONE;
      s2_next.sq.rad = '0;
    end else if (s1_a == '0) begin
      s2_next.kind   = KIND_LINEAR;
      s2_next.sq.rad = '0;
    end else if (disc > 34'sd0) begin
      s2_next.kind = KIND_TWO;
    end else if (disc == 34'sd0) begin
      s2_next.kind = KIND_DOUBLE;
    end else begin
      s2_next.kind = KIND_COMPLEX;
    end
  end

  // Square-root pipeline: entry 0 is stage 2, each further entry one bit.
  root_stage_t sqp   [SqrtN+1];
  logic        sqp_v [SqrtN+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqp_v[0] <= 1'b0;
    end else if (en) begin
      sqp_v[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqp[0] <= s2_next;
    end
  end

  for (genvar i = 0; i < SqrtN; i++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sqp_v[i+1] <= 1'b0;
      end else if (en) begin
        sqp_v[i+1] <= sqp_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sqp[i+1].kind <= sqp[i].kind;
        sqp[i+1].a    <= sqp[i].a;
        sqp[i+1].b    <= sqp[i].b;
        sqp[i+1].c    <= sqp[i].c;
        sqp[i+1].sq   <= sqrt_step(sqp[i].sq);
      end
    end
  end

  // Operand stage: numerators, shared denominator and the signs of the roots.
  root_stage_t        sq_out;
  logic signed [26:0] nb, sx, n1, n2;
  logic signed [DenW-1:0] den;
  logic [26:0]        mag1, mag2;
  div_stage_t         dv_next;

  assign sq_out = sqp[SqrtN];

  always_comb begin
    nb = -(27'(sq_out.b) <<< 8);
    sx = $signed({2'b00, sq_out.sq.root});
    n1 = '0;
    n2 = '0;
    den = 17'sd1;
    case (sq_out.kind)
      KIND_LINEAR: begin
        n1  = -(27'(sq_out.c) <<< 8);
        den = 17'(sq_out.b);
      end
      KIND_TWO: begin
        n1  = nb + sx;
        n2  = nb - sx;
        den = 17'(sq_out.a) <<< 1;
      end
      KIND_DOUBLE: begin
        n1  = nb;
        den = 17'(sq_out.a) <<< 1;
      end
      KIND_COMPLEX: begin
        n1  = nb;
        n2  = sx;
        den = 17'(sq_out.a) <<< 1;
      end
      default: begin
        n1  = '0;
        n2  = '0;
        den = 17'sd1;
      end
    endcase
    mag1 = n1[26] ? 27'(-n1) : n1;
    mag2 = n2[26] ? 27'(-n2) : n2;
    dv_next.kind   = sq_out.kind;
    dv_next.s      = sq_out.sq.root;
    dv_next.den    = den[DenW-1] ? DenW'(-den) : den;
    dv_next.neg1   = n1[26] ^ den[DenW-1];
    dv_next.neg2   = n2[26] ^ den[DenW-1];
    dv_next.d1.rem = '0;
    dv_next.d1.nq  = {mag1[25:0], 8'h00};
    dv_next.d2.rem = '0;
    dv_next.d2.nq  = {mag2[25:0], 8'h00};
  end

  // Divider pipeline: entry 0 is the operand stage, each further entry one bit.
  div_stage_t dvp   [NumW+1];
  logic       dvp_v [NumW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvp_v[0] <= 1'b0;
    end else if (en) begin
      dvp_v[0] <= sqp_v[SqrtN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvp[0] <= dv_next;
    end
  end

  for (genvar j = 0; j < NumW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvp_v[j+1] <= 1'b0;
      end else if (en) begin
        dvp_v[j+1] <= dvp_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvp[j+1].kind <= dvp[j].kind;
        dvp[j+1].s    <= dvp[j].s;
        dvp[j+1].den  <= dvp[j].den;
        dvp[j+1].neg1 <= dvp[j].neg1;
        dvp[j+1].neg2 <= dvp[j].neg2;
        dvp[j+1].d1   <= div_step(dvp[j].d1, dvp[j].den);
        dvp[j+1].d2   <= div_step(dvp[j].d2, dvp[j].den);
      end
    end
  end

  // Output register: sign, saturation and packing.
  div_stage_t  dv_out;
  logic [32:0] r1, r2;

  assign dv_out = dvp[NumW];
  assign r1 = sign_sat(dv_out.d1.nq, dv_out.neg1);
  assign r2 = sign_sat(dv_out.d2.nq, dv_out.neg2);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dvp_v[NumW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {1'b0, 6'b000000, dv_out.s, r2[31:0], r1[31:0]};
      m_axis_tuser <= {r1[32] | r2[32], dv_out.kind};
    end
  end

endmodule

`default_nettype wire

// ===== sv/qrs_checker.sv =====
// ---------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the result stream of the quadratic root solver.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quadratic_root_solver_defines.svh"

module qrs_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [qrs_pkg::OutW-1:0]   m_axis_tdata,
  input wire logic [qrs_pkg::UserW-1:0]  m_axis_tuser
);
  import qrs_pkg::*;

  logic [2:0] kind;
  assign kind = m_axis_tuser[2:0];

  // A stalled beat keeps its contents.
  `QRS_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // No second root for the kinds that have only one.
  `QRS_ASSERT(a_second_zero, m_axis_tvalid && (kind == KIND_NONE || kind == KIND_LINEAR || kind == KIND_DOUBLE) |-> m_axis_tdata[63:32] == 32'h0, "second root not zero")

  // Without a quadratic term or with a zero discriminant the square root is zero.
  `QRS_ASSERT(a_sqrt_zero, m_axis_tvalid && (kind == KIND_NONE || kind == KIND_LINEAR || kind == KIND_DOUBLE) |-> m_axis_tdata[94:64] == 31'h0, "disc_sqrt not zero")

  // No equation gives all-zero results.
  `QRS_ASSERT(a_none_zero, m_axis_tvalid && kind == KIND_NONE |-> m_axis_tdata[31:0] == 32'h0 && !m_axis_tuser[3], "no-equation result not zero")

  // Reset empties the output.
  `QRS_ASSERT_ALWAYS(a_reset, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadratic root solver. Coefficient beats are
// streamed in with random bursts and gaps, results are collected under a
// stall pattern, and each result is compared with a local fixed-point model.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import qrs_pkg::*;

  // One expected solution, holding the fields of the output beat.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
    logic [30:0] dsqrt;
    logic        ovf;
  } solution_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;
  logic [UserW-1:0]    m_axis_tuser;

  logic [InW-1:0] coef_queue[$];     // coefficient beats awaiting the driver
  solution_t      solution_queue[$]; // solutions awaiting their result beat
  int             mismatches = 0;
  int             results_seen = 0;
  int             beats_sent = 0;
  int             kind_count[5];
  int             gap_left = 0;
  int             burst_left = 0;
  int             stall_mode = 0;
  bit             hold_off = 1'b0;

  always #5 clk = ~clk;

  quadratic_root_solver u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Floor square root of a 64-bit value by the classic bit-pair method.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Clamp to the Q16.16 range, noting any clamping in ovf.
  function automatic logic [31:0] clamp_q16(input longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Solves a*x^2 + b*x + c = 0 in fixed point. SystemVerilog integer division
  // truncates toward zero, as the hardware does.
  function automatic solution_t solve_quadratic(input logic [InW-1:0] beat);
    solution_t       r;
    longint          a, b, c, disc, den, nb;
    longint unsigned s;
    a = longint'($signed(beat[15:0]));
    b = longint'($signed(beat[31:16]));
    c = longint'($signed(beat[47:32]));
    r = '0;
    s = 0;
    if (a == 0 && b == 0) begin
      r.kind = KIND_NONE;
    end else if (a == 0) begin
      r.kind  = KIND_LINEAR;
      r.first = clamp_q16((-c * 65536) / b, r.ovf);
    end else begin
      disc = b * b - 4 * a * c;
      den  = 2 * a;
      s    = floor_sqrt((disc < 0 ? -disc : disc) << 16);
      nb   = -b * 256;
      if (disc > 0) begin
        r.kind   = KIND_TWO;
        r.first  = clamp_q16(((nb + longint'(s)) * 256) / den, r.ovf);
        r.second = clamp_q16(((nb - longint'(s)) * 256) / den, r.ovf);
      end else if (disc == 0) begin
        r.kind  = KIND_DOUBLE;
        r.first = clamp_q16((-b * 65536) / den, r.ovf);
      end else begin
        r.kind   = KIND_COMPLEX;
        r.first  = clamp_q16((-b * 65536) / den, r.ovf);
        r.second = clamp_q16((longint'(s) * 256) / den, r.ovf);
      end
    end
    r.dsqrt = s[30:0];
    return r;
  endfunction

  function automatic logic [InW-1:0] pack_coefs(input int a, input int b, input int c);
    return {c[15:0], b[15:0], a[15:0]};
  endfunction

  // Random coefficient: half full range, otherwise zero, small, mid-size or an extreme.
  function automatic int rand_coef();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32767 : -32768;
      1:       return 0;
      2, 3:    return int'($urandom_range(0, 64)) - 32;
      4:       return int'($urandom_range(0, 4096)) - 2048;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // Driver: bursts of beats separated by random gaps. The handshake is judged
  // on the values sampled at this edge, so a held beat is never re-driven.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) beats_sent <= beats_sent + 1;
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (coef_queue.size() != 0 && !hold_off) begin
        s_axis_tdata  <= coef_queue[0];
        solution_queue.push_back(solve_quadratic(coef_queue[0]));
        void'(coef_queue.pop_front());
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: phases of always ready, random stalls and
  // long stalls, switched now and then.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: every accepted result beat is checked against the oldest solution.
  always @(posedge clk) begin
    solution_t got;
    solution_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[2:0], m_axis_tdata[31:0], m_axis_tdata[63:32],
             m_axis_tdata[94:64], m_axis_tuser[3]};
      results_seen <= results_seen + 1;
      if (solution_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("ERROR: result beat with nothing expected");
      end else begin
        want = solution_queue.pop_front();
        if (want.kind <= KIND_COMPLEX) kind_count[want.kind] <= kind_count[want.kind] + 1;
        if (got !== want || m_axis_tdata[95] !== 1'b0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ERROR: expected kind %0d r1 %h r2 %h sq %h ovf %0d, got kind %0d r1 %h r2 %h sq %h ovf %0d",
                     want.kind, want.first, want.second, want.dsqrt, want.ovf,
                     got.kind, got.first, got.second, got.dsqrt, got.ovf);
        end
      end
    end
  end

  initial begin
    // Directed part: degenerate equations, linear saturation, each root kind
    // and the coefficient extremes.
    coef_queue.push_back(pack_coefs(0, 0, 0));
    coef_queue.push_back(pack_coefs(0, 0, -32768));
    coef_queue.push_back(pack_coefs(0, 1, -32768));
    coef_queue.push_back(pack_coefs(0, -1, -32768));
    coef_queue.push_back(pack_coefs(0, 1, 32767));
    coef_queue.push_back(pack_coefs(0, -32768, 32767));
    coef_queue.push_back(pack_coefs(256, 0, -1024));
    coef_queue.push_back(pack_coefs(256, -512, 256));
    coef_queue.push_back(pack_coefs(256, 0, 256));
    coef_queue.push_back(pack_coefs(1, -32768, 0));
    coef_queue.push_back(pack_coefs(1, 32767, 1));
    coef_queue.push_back(pack_coefs(-1, 32767, 32767));
    coef_queue.push_back(pack_coefs(1, 0, 32767));
    coef_queue.push_back(pack_coefs(-1, 0, 32767));
    coef_queue.push_back(pack_coefs(-32768, -32768, -32768));
    coef_queue.push_back(pack_coefs(32767, 32767, 32767));
    coef_queue.push_back(pack_coefs(-32768, 32767, -32768));
    coef_queue.push_back(pack_coefs(32767, -32768, -32768));
    coef_queue.push_back(pack_coefs(-32768, 0, 32767));
    coef_queue.push_back(pack_coefs(1, 2, 1));
    coef_queue.push_back(pack_coefs(-1, -1, -1));
    coef_queue.push_back(pack_coefs(-256, 512, -256));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for the directed beats to drain completely before random traffic.
    wait (coef_queue.size() == 0);
    hold_off = 1'b1;
    @(posedge clk);
    wait (solution_queue.size() == 0 && !s_axis_tvalid);
    hold_off = 1'b0;

    for (int i = 0; i < 550; i++) begin
      int a, b, c, r;
      a = rand_coef();
      b = rand_coef();
      c = rand_coef();
      // Build double roots on purpose now and then: b = 2k, a = 1, c = k*k.
      if ($urandom_range(0, 15) == 0) begin
        r = int'($urandom_range(0, 180)) - 90;
        a = 1;
        b = 2 * r;
        c = r * r;
      end
      coef_queue.push_back(pack_coefs(a, b, c));
    end

    wait (coef_queue.size() == 0 && !s_axis_tvalid);
    wait (solution_queue.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d coefficient beats, %0d results checked.", beats_sent, results_seen);
    $display("Kinds seen: none %0d, linear %0d, two real %0d, double %0d, complex %0d.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
    if (mismatches == 0 && solution_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Timeout with %0d solutions outstanding.", solution_queue.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
